### rtl/two_stack_bounded_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-stack bounded queue
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_BOUNDED_QUEUE_TOP_DEFINES_SVH
`define TWO_STACK_BOUNDED_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TSBQ_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tsbq check failed");
`define TSBQ_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tsbq check failed");
`else
`define TSBQ_ASSERT_NOW(name, pre, post)
`define TSBQ_ASSERT_NEXT(name, pre, post)
`endif

`endif

### rtl/tsbq_pkg.sv
// ----------------------------------------------------------------------------
// tsbq_pkg
// Shared widths, codes and defaults of the two-stack bounded queue.
// ----------------------------------------------------------------------------
package tsbq_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int ACT_W           = 2;
  localparam int STS_W           = 2;
  localparam int CNT_W           = 6;
  localparam int CFG_W           = 5;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [CFG_W-1:0] MAX_SIZE_RST = 5'd16;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FRONT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BACK  = 2'd3;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

endpackage

### rtl/tsbq_ram.sv
// ----------------------------------------------------------------------------
// tsbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tsbq_ram #(
  parameter int WIDTH = tsbq_pkg::DATA_W,
  parameter int DEPTH = tsbq_pkg::STACK_DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/two_stack_bounded_queue_top.sv
// ----------------------------------------------------------------------------
// two_stack_bounded_queue_top
// FIFO queue made of two bounded stacks held in RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_*    | slave     | tdata: action[1:0], push_value[33:2], zero[39:34]
//  out_*   | master    | tdata: status[1:0], data_out[33:2], item_count[39:34]
//  cfg_*   | write     | max_stack_size[4:0]
//
// An item passes from acceptance through S_DECIDE to S_FIN when it is refused or
// finds the queue empty, through S_DECIDE, S_PUSH and S_FIN for a push, and
// through S_DECIDE, S_READ, S_GRAB and S_FIN for pop, front and back. A move of
// one stack into the other runs in S_MOVE, one entry per cycle, through the read
// port of the source RAM and the write port of the destination RAM. in_tready
// is high only while the sequencer is idle; a finished result waits in the
// output register. Reset is synchronous: both stacks become empty and
// max_stack_size 16.
// ----------------------------------------------------------------------------
`include "two_stack_bounded_queue_top_defines.svh"

module two_stack_bounded_queue_top #(
  parameter int STACK_DEPTH = tsbq_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // action[1:0], push_value[33:2], zero[39:34]
  input  logic [tsbq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], data_out[33:2], item_count[39:34]
  output logic [tsbq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [tsbq_pkg::CFG_W-1:0]         cfg_wr_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = (CW > tsbq_pkg::CFG_W) ? CW : tsbq_pkg::CFG_W;
  localparam int DW = tsbq_pkg::DATA_W;
  localparam int SW = tsbq_pkg::STS_W;

  localparam logic [CW-1:0] SD_N = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MOVE   = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_GRAB   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [2:0]                  after_r, after_nxt;
  logic [CW-1:0]               in_n_r, in_n_nxt;
  logic [CW-1:0]               out_n_r, out_n_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        dir_r, dir_nxt;     // 1: out-stack into in-stack
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               wa_r, wa_nxt;
  logic                        rd_side_r, rd_side_nxt; // 1: read in-stack top
  logic [tsbq_pkg::CFG_W-1:0]  max_r;
  logic [tsbq_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [DW-1:0]               val_r, val_nxt;
  logic [SW-1:0]               res_status_r, res_status_nxt;
  logic [DW-1:0]               res_data_r, res_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [SW-1:0]               out_status_r, out_status_nxt;
  logic [DW-1:0]               out_data_r, out_data_nxt;
  logic [tsbq_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [EW-1:0]  max_e;
  logic [CW-1:0]  cap;
  logic [CW-1:0]  mv_in, mv_out;
  logic [CW-1:0]  in_n_m1, out_n_m1;
  logic [CW:0]    total;
  logic           in_full;

  logic           in_we, out_we;
  logic [AW-1:0]  in_wa;
  logic [DW-1:0]  in_wd;
  logic [DW-1:0]  in_rdata, out_rdata;

  // Capacity is max_stack_size limited to the range 1 .. STACK_DEPTH.
  always_comb begin
    max_e = EW'(max_r);
    if (max_e == '0) begin
      cap = CW'(1);
    end else if (max_e > EW'(STACK_DEPTH)) begin
      cap = SD_N;
    end else begin
      cap = CW'(max_e);
    end
  end

  assign mv_in    = (in_n_r < cap) ? in_n_r : cap;
  assign mv_out   = (out_n_r < cap) ? out_n_r : cap;
  assign in_full  = (in_n_r >= cap);
  assign in_n_m1  = in_n_r - CW'(1);
  assign out_n_m1 = out_n_r - CW'(1);
  assign total    = {1'b0, in_n_r} + {1'b0, out_n_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_data_r, out_status_r};

  // Each RAM always reads its current top; a move shrinks the source by one
  // a cycle, so each entry arrives in the cycle after its read.
  assign in_wa = (state_r == S_PUSH) ? in_n_r[AW-1:0] : wa_r;
  assign in_wd = (state_r == S_PUSH) ? val_r : out_rdata;

  tsbq_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_in_ram (
    .clk     (clk),
    .wr_en   (in_we),
    .wr_addr (in_wa),
    .wr_data (in_wd),
    .rd_addr (in_n_m1[AW-1:0]),
    .rd_data (in_rdata)
  );

  tsbq_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_out_ram (
    .clk     (clk),
    .wr_en   (out_we),
    .wr_addr (wa_r),
    .wr_data (in_rdata),
    .rd_addr (out_n_m1[AW-1:0]),
    .rd_data (out_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    after_nxt      = after_r;
    in_n_nxt       = in_n_r;
    out_n_nxt      = out_n_r;
    cnt_nxt        = cnt_r;
    dir_nxt        = dir_r;
    pend_nxt       = pend_r;
    wa_nxt         = wa_r;
    rd_side_nxt    = rd_side_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_cnt_nxt    = out_cnt_r;
    in_we          = 1'b0;
    out_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tdata[tsbq_pkg::ACT_W-1:0];
          val_nxt   = in_tdata[tsbq_pkg::ACT_W +: DW];
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_status_nxt = tsbq_pkg::STS_OK;
        res_data_nxt   = '0;
        if (act_r == tsbq_pkg::ACT_PUSH) begin
          if (in_full && out_n_r != '0) begin
            res_status_nxt = tsbq_pkg::STS_FULL;
            state_nxt      = S_FIN;
          end else if (in_full) begin
            dir_nxt   = 1'b0;
            cnt_nxt   = mv_in;
            after_nxt = S_PUSH;
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_PUSH;
          end
        end else if (in_n_r == '0 && out_n_r == '0) begin
          res_status_nxt = tsbq_pkg::STS_EMPTY;
          state_nxt      = S_FIN;
        end else if (act_r == tsbq_pkg::ACT_BACK) begin
          rd_side_nxt = 1'b1;
          after_nxt   = S_READ;
          if (in_n_r == '0) begin
            dir_nxt   = 1'b1;
            cnt_nxt   = mv_out;
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_READ;
          end
        end else begin
          rd_side_nxt = 1'b0;
          after_nxt   = S_READ;
          if (out_n_r == '0) begin
            dir_nxt   = 1'b0;
            cnt_nxt   = mv_in;
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_MOVE: begin
        // The write of the entry read in the previous cycle.
        if (pend_r) begin
          in_we  = dir_r;
          out_we = !dir_r;
        end
        if (cnt_r != '0) begin
          cnt_nxt  = cnt_r - CW'(1);
          pend_nxt = 1'b1;
          if (dir_r) begin
            out_n_nxt = out_n_r - CW'(1);
            in_n_nxt  = in_n_r + CW'(1);
            wa_nxt    = in_n_r[AW-1:0];
          end else begin
            in_n_nxt  = in_n_r - CW'(1);
            out_n_nxt = out_n_r + CW'(1);
            wa_nxt    = out_n_r[AW-1:0];
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = after_r;
        end
      end
      S_PUSH: begin
        if (in_n_r < SD_N) begin
          in_we        = 1'b1;
          in_n_nxt     = in_n_r + CW'(1);
          res_data_nxt = val_r;
        end else begin
          res_status_nxt = tsbq_pkg::STS_FULL;
        end
        state_nxt = S_FIN;
      end
      S_READ: begin
        state_nxt = S_GRAB;
      end
      S_GRAB: begin
        res_data_nxt = rd_side_r ? in_rdata : out_rdata;
        if (act_r == tsbq_pkg::ACT_POP) begin
          out_n_nxt = out_n_r - CW'(1);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_cnt_nxt    = tsbq_pkg::CNT_W'(total);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_n_r      <= '0;
      out_n_r     <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= tsbq_pkg::MAX_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      in_n_r      <= in_n_nxt;
      out_n_r     <= out_n_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    after_r      <= after_nxt;
    dir_r        <= dir_nxt;
    wa_r         <= wa_nxt;
    rd_side_r    <= rd_side_nxt;
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  `TSBQ_ASSERT_NOW(a_depth_bound, 1'b1, (in_n_r <= SD_N) && (out_n_r <= SD_N))
  `TSBQ_ASSERT_NOW(a_move_drains, (state_r == S_MOVE) && (cnt_r == '0), pend_r)
  `TSBQ_ASSERT_NOW(a_empty_result,
                   (state_r == S_FIN) && (res_status_r == tsbq_pkg::STS_EMPTY),
                   (in_n_r == '0) && (out_n_r == '0))
  `TSBQ_ASSERT_NOW(a_idle_no_write, in_tready, !pend_r)
  `TSBQ_ASSERT_NEXT(a_accept_decide, in_tvalid && in_tready, state_r == S_DECIDE)

endmodule
